FILE: rtl/core/fir_sat_pkg.sv
// Shared types and constants for the saturating FIR filter.
`timescale 1ns / 1ps
package fir_sat_pkg;

  localparam int MaxTaps     = 64;
  localparam int SampleWidth = 16;
  localparam int CoefWidth   = 16;
  localparam int ProdWidth   = SampleWidth + CoefWidth;
  localparam int AccWidth    = ProdWidth + $clog2(MaxTaps);
  localparam int TapIdxWidth = 6;
  localparam int TapCntWidth = 7;
  localparam int ShiftWidth  = 5;
  localparam int CfgIdxWidth = 1;
  localparam int CfgDataWidth = 7;
  // run counter value at which the last partial sum has settled
  localparam int RunLast     = MaxTaps + 1;
  localparam int RunCntWidth = $clog2(RunLast + 1);

  localparam logic [TapCntWidth-1:0] TapsReset  = TapCntWidth'(64);
  localparam logic [ShiftWidth-1:0]  ShiftReset = ShiftWidth'(15);

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_COEF   = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_TAPS  = 1'b0,
    CFG_SHIFT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    kind_e                          kind;
    logic signed [SampleWidth-1:0]  sample_in;
    logic [TapIdxWidth-1:0]         tap_index;
    logic signed [CoefWidth-1:0]    tap_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample_out;
    logic                          clipped;
  } out_item_t;

  typedef struct packed {
    logic shift_en;
    logic coef_we;
    logic tap_on;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/fir_sat_cell.sv
// One tap cell: history sample, coefficient, product and partial sum.
`timescale 1ns / 1ps
module fir_sat_cell (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  fir_sat_pkg::cell_ctrl_t                    ctrl_i,
  input  logic signed [fir_sat_pkg::SampleWidth-1:0] sample_i,
  input  logic signed [fir_sat_pkg::CoefWidth-1:0]   coef_i,
  input  logic signed [fir_sat_pkg::AccWidth-1:0]    psum_i,
  output logic signed [fir_sat_pkg::SampleWidth-1:0] sample_o,
  output logic signed [fir_sat_pkg::AccWidth-1:0]    psum_o
);

  logic signed [fir_sat_pkg::SampleWidth-1:0] hist_q;
  logic signed [fir_sat_pkg::CoefWidth-1:0]   coef_q;
  logic signed [fir_sat_pkg::ProdWidth-1:0]   prod_q, prod_d;
  logic signed [fir_sat_pkg::AccWidth-1:0]    psum_q, psum_d;

  always_comb begin
    // widen both operands first so the full signed product is kept
    prod_d = fir_sat_pkg::ProdWidth'(hist_q) * fir_sat_pkg::ProdWidth'(coef_q);
    if (ctrl_i.tap_on) begin
      psum_d = psum_i + fir_sat_pkg::AccWidth'(prod_q);
    end else begin
      psum_d = psum_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      coef_q <= '0;
    end else begin
      if (ctrl_i.shift_en) begin
        hist_q <= sample_i;
      end
      if (ctrl_i.coef_we) begin
        coef_q <= coef_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    psum_q <= psum_d;
  end

  assign sample_o = hist_q;
  assign psum_o   = psum_q;

endmodule

FILE: rtl/core/fir_sat_out.sv
// Output stage: arithmetic shift, saturation to sample width, result register.
`timescale 1ns / 1ps
module fir_sat_out (
  input  logic                                    clk_i,
  input  logic                                    load_i,
  input  logic signed [fir_sat_pkg::AccWidth-1:0] acc_i,
  input  logic [fir_sat_pkg::ShiftWidth-1:0]      shift_i,
  output fir_sat_pkg::out_item_t                  item_o
);

  localparam int AccW = fir_sat_pkg::AccWidth;
  localparam int SmpW = fir_sat_pkg::SampleWidth;
  localparam logic signed [AccW-1:0] SatHi = {{(AccW-SmpW+1){1'b0}}, {(SmpW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatLo = ~SatHi;

  logic signed [AccW-1:0] shifted;
  fir_sat_pkg::out_item_t item_q, item_d;

  always_comb begin
    shifted = acc_i >>> shift_i;
    priority if (shifted > SatHi) begin
      item_d.sample_out = SatHi[SmpW-1:0];
      item_d.clipped    = 1'b1;
    end else if (shifted < SatLo) begin
      item_d.sample_out = SatLo[SmpW-1:0];
      item_d.clipped    = 1'b1;
    end else begin
      item_d.sample_out = shifted[SmpW-1:0];
      item_d.clipped    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

FILE: rtl/core/fir_filter_saturating.sv
// Top level of the saturating direct-form FIR filter.
`timescale 1ns / 1ps
// Direct-form FIR filter built as a row of MaxTaps tap cells. Each cell holds
// one history sample and one Q1.15 coefficient, multiplies them into a
// register and adds the product to the partial sum handed on by its left
// neighbor. A coefficient transaction (kind 1) writes the tap and returns no
// result. A sample transaction (kind 0) shifts the history by one cell, then
// the partial sum ripples down the row, one cell per cycle. Once the last
// partial sum has settled and the output register is free, the result is
// loaded there and only then is the next transaction taken. Cells at or
// beyond taps_in_use add nothing. The sum is shifted right arithmetically by
// result_shift and saturated to 16 bits; clipped flags saturation. A finished
// result waits in the output register while coefficient writes continue.
// Configuration writes are meant for idle periods.
module fir_filter_saturating (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  fir_sat_pkg::in_item_t                   in_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output fir_sat_pkg::out_item_t                  out_data_o,
  input  logic                                    cfg_we_i,
  input  logic [fir_sat_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [fir_sat_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  localparam int N = fir_sat_pkg::MaxTaps;

  fir_sat_pkg::state_e state_q, state_d;
  logic [fir_sat_pkg::RunCntWidth-1:0] cnt_q, cnt_d;
  logic [fir_sat_pkg::TapCntWidth-1:0] taps_q;
  logic [fir_sat_pkg::ShiftWidth-1:0]  shift_q;
  logic out_valid_q, out_valid_d;
  logic in_fire, sample_fire, coef_fire, load_out;

  logic signed [fir_sat_pkg::SampleWidth-1:0] hist_w [N];
  logic signed [fir_sat_pkg::AccWidth-1:0]    psum_w [N];

  assign in_ready_o  = (state_q == fir_sat_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign sample_fire = in_fire && (in_data_i.kind == fir_sat_pkg::KIND_SAMPLE);
  assign coef_fire   = in_fire && (in_data_i.kind == fir_sat_pkg::KIND_COEF);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      fir_sat_pkg::ST_IDLE: begin
        if (sample_fire) begin
          state_d = fir_sat_pkg::ST_RUN;
          cnt_d   = '0;
        end
      end
      fir_sat_pkg::ST_RUN: begin
        if (cnt_q == fir_sat_pkg::RunCntWidth'(fir_sat_pkg::RunLast)) begin
          if (!out_valid_q || out_ready_i) begin
            load_out    = 1'b1;
            out_valid_d = 1'b1;
            state_d     = fir_sat_pkg::ST_IDLE;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = fir_sat_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fir_sat_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      taps_q      <= fir_sat_pkg::TapsReset;
      shift_q     <= fir_sat_pkg::ShiftReset;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (fir_sat_pkg::cfg_reg_e'(cfg_idx_i))
          fir_sat_pkg::CFG_TAPS:  taps_q  <= cfg_data_i[fir_sat_pkg::TapCntWidth-1:0];
          fir_sat_pkg::CFG_SHIFT: shift_q <= cfg_data_i[fir_sat_pkg::ShiftWidth-1:0];
          default: ;
        endcase
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    fir_sat_pkg::cell_ctrl_t                    ctrl;
    logic signed [fir_sat_pkg::SampleWidth-1:0] smp_in;
    logic signed [fir_sat_pkg::AccWidth-1:0]    acc_in;

    assign ctrl.shift_en = sample_fire;
    assign ctrl.coef_we  = coef_fire && (32'(in_data_i.tap_index) == 32'(k));
    // taps_in_use above the row length simply enables every cell
    assign ctrl.tap_on   = (32'(taps_q) > 32'(k));

    if (k == 0) begin : g_head
      assign smp_in = in_data_i.sample_in;
      assign acc_in = '0;
    end else begin : g_body
      assign smp_in = hist_w[k-1];
      assign acc_in = psum_w[k-1];
    end

    fir_sat_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sample_i (smp_in),
      .coef_i   (in_data_i.tap_value),
      .psum_i   (acc_in),
      .sample_o (hist_w[k]),
      .psum_o   (psum_w[k])
    );
  end

  fir_sat_out u_out (
    .clk_i   (clk_i),
    .load_i  (load_out),
    .acc_i   (psum_w[N-1]),
    .shift_i (shift_q),
    .item_o  (out_data_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

FILE: verif/tb_fir_filter_saturating.sv
// Self-checking testbench for the saturating FIR filter: random stream with predicted outputs.
`timescale 1ns / 1ps
module tb_fir_filter_saturating;
  import fir_sat_pkg::*;

  localparam int CycleLimit    = 1_000_000;
  localparam int PhaseCount    = 12;
  localparam int ItemsPerPhase = 120;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_SPARSE
  } ready_mode_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_data_o;
  logic                    cfg_we_i   = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i  = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  // filter state as the block should hold it
  logic signed [SampleWidth-1:0] sample_line [MaxTaps] = '{default: '0};
  logic signed [CoefWidth-1:0]   coef_bank   [MaxTaps] = '{default: '0};
  logic [TapCntWidth-1:0]        taps_cfg  = TapsReset;
  logic [ShiftWidth-1:0]         shift_cfg = ShiftReset;

  in_item_t    pending_items[$];
  out_item_t   expected_outputs[$];
  out_item_t   oldest_output;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  logic        drive_next;
  ready_mode_e ready_mode = READY_ALWAYS;
  int          ready_mode_left = 0;

  int phase_taps  [8] = '{1, 0, 127, 65, 2, 64, 33, 64};
  int phase_shift [8] = '{0, 31, 'h67, 20, 0, 31, 15, 15};

  fir_filter_saturating u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Push a sample into the history line and return the filtered output.
  function automatic out_item_t filter_sample(logic signed [SampleWidth-1:0] sample);
    longint    acc;
    longint    shifted;
    int        n;
    out_item_t res;
    for (int k = MaxTaps - 1; k > 0; k--) sample_line[k] = sample_line[k-1];
    sample_line[0] = sample;
    n = (taps_cfg > MaxTaps) ? MaxTaps : int'(taps_cfg);
    acc = 0;
    for (int k = 0; k < n; k++) acc += longint'(sample_line[k]) * longint'(coef_bank[k]);
    shifted = acc >>> shift_cfg;
    res.clipped = 1'b0;
    if (shifted > 32767) begin
      shifted = 32767;
      res.clipped = 1'b1;
    end else if (shifted < -32768) begin
      shifted = -32768;
      res.clipped = 1'b1;
    end
    res.sample_out = shifted[SampleWidth-1:0];
    return res;
  endfunction

  // Mix of extremes, small and mid-size values, and the full range.
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3:    return 16'($urandom_range(0, 511) - 256);
      4, 5:    return 16'($urandom_range(0, 8191) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    if ($urandom_range(0, 9) < 3) it.kind = KIND_COEF;
    else it.kind = KIND_SAMPLE;
    it.sample_in = pick_value();
    it.tap_index = TapIdxWidth'($urandom_range(0, MaxTaps - 1));
    it.tap_value = pick_value();
    return it;
  endfunction

  task automatic queue_coef(int idx, logic signed [CoefWidth-1:0] val);
    in_item_t it;
    it.kind      = KIND_COEF;
    it.sample_in = SampleWidth'($urandom);
    it.tap_index = TapIdxWidth'(idx);
    it.tap_value = val;
    pending_items.push_back(it);
  endtask

  task automatic queue_sample(logic signed [SampleWidth-1:0] val);
    in_item_t it;
    it.kind      = KIND_SAMPLE;
    it.sample_in = val;
    it.tap_index = TapIdxWidth'($urandom);
    it.tap_value = CoefWidth'($urandom);
    pending_items.push_back(it);
  endtask

  // Block drained: nothing queued, nothing in flight, then let the tap row settle.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_outputs.size() != 0)
      @(posedge clk_i);
    repeat (RunLast + 4) @(posedge clk_i);
  endtask

  task automatic apply_setting(int taps, int shift_data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TAPS;
    cfg_data_i <= CfgDataWidth'(taps);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SHIFT;
    cfg_data_i <= CfgDataWidth'(shift_data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    taps_cfg  = TapCntWidth'(taps);
    shift_cfg = ShiftWidth'(shift_data);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      drive_next = 1'b0;
      if (in_valid_i && in_ready_o) begin
        if (in_data_i.kind == KIND_COEF) coef_bank[in_data_i.tap_index] = in_data_i.tap_value;
        else expected_outputs.push_back(filter_sample(in_data_i.sample_in));
        void'(pending_items.pop_front());
      end
      if (in_valid_i && !in_ready_o) begin
        drive_next = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        drive_next = 1'b1;
        in_data_i <= pending_items[0];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 4))
            0, 1:    gap_left = 0;
            2, 3:    gap_left = $urandom_range(1, 8);
            default: gap_left = $urandom_range(9, 90);
          endcase
        end
      end
      in_valid_i <= drive_next;
    end
  end

  // Receiver: checks each transaction, stalls in modes of random length.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected result: sample_out %0d clipped %0b",
                 out_data_o.sample_out, out_data_o.clipped);
          fail_count++;
        end else begin
          oldest_output = expected_outputs.pop_front();
          if (out_data_o.sample_out !== oldest_output.sample_out) begin
            $error("sample_out: expected %0d, actual %0d",
                   oldest_output.sample_out, out_data_o.sample_out);
            fail_count++;
          end
          if (out_data_o.clipped !== oldest_output.clipped) begin
            $error("clipped: expected %0b, actual %0b",
                   oldest_output.clipped, out_data_o.clipped);
            fail_count++;
          end
        end
      end
      if (ready_mode_left == 0) begin
        ready_mode      = ready_mode_e'($urandom_range(0, 3));
        ready_mode_left = $urandom_range(10, 300);
      end else begin
        ready_mode_left--;
      end
      case (ready_mode)
        READY_ALWAYS: out_ready_i <= 1'b1;
        READY_COIN:   out_ready_i <= $urandom_range(0, 1) == 1;
        READY_MOSTLY: out_ready_i <= $urandom_range(0, 7) != 0;
        default:      out_ready_i <= $urandom_range(0, 15) == 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme taps and samples, clipping both ways, at reset settings
    @(negedge clk_i);
    queue_sample(16'sh7fff);
    queue_coef(0, 16'sh8000);
    queue_coef(MaxTaps - 1, 16'sh7fff);
    queue_sample(16'sh7fff);
    queue_sample(16'sh8000);
    queue_coef(1, 16'sh8000);
    queue_sample(16'sh7fff);
    queue_sample(16'sh7fff);
    queue_sample(16'sh0000);
    queue_sample(-16'sd1);
    queue_sample(16'sd1);
    queue_coef(1, 16'sh0000);
    queue_coef(2, 16'sh4000);
    queue_sample(16'sh8000);
    queue_sample(16'sh8000);
    queue_sample(16'sd12345);
    wait_idle();

    // zero taps, over-range taps and both shift extremes are in the table
    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 8) apply_setting(phase_taps[p], phase_shift[p]);
      else apply_setting($urandom_range(0, 127), $urandom_range(0, 127));
      @(negedge clk_i);
      for (int i = 0; i < ItemsPerPhase; i++) pending_items.push_back(random_item());
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/fir_sat_pkg.sv
rtl/core/fir_sat_cell.sv
rtl/core/fir_sat_out.sv
rtl/core/fir_filter_saturating.sv
verif/tb_fir_filter_saturating.sv
